>>> hdl/distance_weighted_seed_picker_defines.svh
// Assertion macros for the seed picker
`ifndef DISTANCE_WEIGHTED_SEED_PICKER_DEFINES_SVH
`define DISTANCE_WEIGHTED_SEED_PICKER_DEFINES_SVH
`ifndef SYNTH
`define DWSP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define DWSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DWSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DWSP_ASSERT(label, cond, msg)
`define DWSP_ASSERT_IMP(label, ante, cons, msg)
`define DWSP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/dwsp_pkg.sv
package dwsp_pkg;
    localparam int MAX_POINTS   = 256;
    localparam int NUM_CLUSTERS = 5;
    localparam int PW = $clog2(MAX_POINTS);        // point index width
    localparam int CW = 4;                         // cluster field width
    localparam int KW = $clog2(NUM_CLUSTERS + 1);  // seed counter width
    localparam int NW = PW + 1;                    // point count width
    localparam int DIST_CAP = 64;
    localparam int COST_CAP = 32767;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PICK  = 2'd1;
    localparam logic [1:0] OP_RCLUS = 2'd2;
    localparam logic [1:0] OP_RPNT  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_INIT, S_SEARCH, S_TURN, S_SCAN, S_RDC, S_RDP, S_DONE, S_OUT
    } state_t;

    typedef struct packed {
        logic start_mod;   // begin random mod divisor
        logic mod_total;   // divisor is total cost, else point count
        logic clr_idx;
        logic seed_init;   // first seed from remainder, else default to last point
        logic step_idx;
        logic init_pass;   // first seed pass
        logic search;      // prefix search pass
        logic scan;        // reassignment pass
        logic commit_seed;
        logic load_inp;
        logic capture;     // capture result fields
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic idx_last;
        logic found;
        logic full;
        logic zero_cost;
        logic first;       // no seed chosen yet
    } sts_t;
endpackage

>>> hdl/dwsp_if.sv
interface dwsp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  row_point;
    logic [7:0]  col_point;
    logic [6:0]  pair_distance;
    logic [31:0] random_word;
    logic [3:0]  cluster_select;
    modport source (output valid, opcode, row_point, col_point, pair_distance,
                    random_word, cluster_select, input ready);
    modport sink (input valid, opcode, row_point, col_point, pair_distance,
                  random_word, cluster_select, output ready);
endinterface

interface dwsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  seed_point;
    logic [3:0]  seed_number;
    logic [14:0] cluster_cost;
    logic [14:0] total_cost;
    logic [6:0]  point_distance;
    modport source (output valid, status, seed_point, seed_number, cluster_cost,
                    total_cost, point_distance, input ready);
    modport sink (input valid, status, seed_point, seed_number, cluster_cost,
                  total_cost, point_distance, output ready);
endinterface

>>> hdl/dwsp_moddiv.sv
// Restoring remainder, one quotient bit a cycle.
module dwsp_moddiv
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [14:0] divisor,
    output logic        done,
    output logic [14:0] remainder
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] q_reg, q_next;
    logic [15:0] r_reg, r_next;
    logic [14:0] d_reg, d_next;
    logic [16:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[31]} - {2'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            q_next    = dividend;
            r_next    = 16'd0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[30:0], 1'b0};
            if (!trial[16])
                r_next = trial[15:0];
            else
                r_next = {r_reg[14:0], q_reg[31]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd0) ? 1'b0 : !busy_reg;
    assign remainder = r_reg[14:0];
endmodule

>>> hdl/dwsp_datapath.sv
`include "distance_weighted_seed_picker_defines.svh"
module dwsp_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  dwsp_pkg::cmd_t     cmd,
    output dwsp_pkg::sts_t     sts,
    input  logic [1:0]         opcode,
    input  logic [7:0]         row_point,
    input  logic [7:0]         col_point,
    input  logic [6:0]         pair_distance,
    input  logic [31:0]        random_word,
    input  logic [3:0]         cluster_select,
    input  logic [8:0]         point_count,
    input  logic               do_load,
    output logic [1:0]         status,
    output logic [7:0]         seed_point,
    output logic [3:0]         seed_number,
    output logic [14:0]        cluster_cost,
    output logic [14:0]        total_cost,
    output logic [6:0]         point_distance
);
    localparam int PW = dwsp_pkg::PW;
    localparam int KW = dwsp_pkg::KW;
    localparam int NC = dwsp_pkg::NUM_CLUSTERS;

    logic [6:0] dist_mem [dwsp_pkg::MAX_POINTS*dwsp_pkg::MAX_POINTS];
    logic [6:0] near_mem [dwsp_pkg::MAX_POINTS];
    logic [3:0] asg_mem  [dwsp_pkg::MAX_POINTS];
    logic [14:0] ccost_reg [NC];
    logic [7:0]  seedp_reg [NC];
    logic [KW-1:0] chosen_reg;
    logic [14:0] total_reg;

    logic [8:0]  n_act;
    logic [31:0] rnd_reg;
    logic [PW-1:0] row_reg;
    logic [PW-1:0] col_reg;
    logic [3:0]  csel_reg;
    logic [1:0]  op_reg;
    logic        full_l_reg, zero_l_reg;
    logic [PW-1:0] idx_reg, idx_d_reg;
    logic        pass_v_reg;
    logic [PW-1:0] seed_reg;
    logic [15:0] run_reg;
    logic        found_reg;
    logic [14:0] acc_total_reg;
    logic [14:0] acc_c_reg [NC];
    logic [6:0]  drd_reg, nrd_reg;
    logic [3:0]  ard_reg;
    logic        mod_done;
    logic [14:0] rem;
    logic        pass_i, pass_s, pass_r;
    logic        first;
    logic        wr_ok;
    logic [1:0]  st_next;
    logic [7:0]  sp_next;
    logic [3:0]  sn_next;
    logic [14:0] cc_next;
    logic [14:0] tc_next;
    logic [6:0]  pd_next;

    // clamp of point count
    always_comb
    begin
        if (point_count < 9'd2)
            n_act = 9'd2;
        else if (point_count > 9'(dwsp_pkg::MAX_POINTS))
            n_act = 9'(dwsp_pkg::MAX_POINTS);
        else
            n_act = point_count;
    end

    assign first = (chosen_reg == '0);
    assign wr_ok = do_load && ({1'b0, row_point} < n_act) && ({1'b0, col_point} < n_act);

    dwsp_moddiv u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_mod),
        .dividend  (rnd_reg),
        .divisor   (cmd.mod_total ? total_reg : {6'd0, n_act}),
        .done      (mod_done),
        .remainder (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_inp)
        begin
            rnd_reg    <= random_word;
            row_reg    <= row_point;
            col_reg    <= col_point;
            csel_reg   <= cluster_select;
            op_reg     <= opcode;
            full_l_reg <= sts.full;
            zero_l_reg <= sts.zero_cost;
        end
        if (wr_ok)
            dist_mem[{row_point, col_point}] <=
                (pair_distance > 7'd64) ? 7'd64 : pair_distance;
    end

    // pass pipeline: read at idx, then act on the registered read data
    assign pass_i = cmd.init_pass;
    assign pass_s = cmd.search;
    assign pass_r = cmd.scan;

    always_ff @(posedge clk)
    begin
        drd_reg <= dist_mem[{idx_reg, pass_i ? rem[PW-1:0] : seed_reg}];
        nrd_reg <= near_mem[pass_i || pass_s || pass_r ? idx_reg : row_reg];
        ard_reg <= asg_mem[pass_i || pass_s || pass_r ? idx_reg : row_reg];
        idx_d_reg <= idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_v_reg <= 1'b0;
            idx_reg    <= '0;
            chosen_reg <= '0;
            total_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            pass_v_reg <= cmd.step_idx;
            if (cmd.clr_idx)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step_idx)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.search && pass_v_reg && !found_reg &&
                (run_reg + {9'd0, nrd_reg}) > {1'b0, rem})
                found_reg <= 1'b1;
            if (cmd.commit_seed)
            begin
                chosen_reg <= chosen_reg + 1'b1;
                total_reg  <= acc_total_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_idx)
        begin
            run_reg       <= '0;
            acc_total_reg <= '0;
            for (int c = 0; c < NC; c++)
                acc_c_reg[c] <= '0;
        end
        // a search that never passes the draw falls back to the last point
        if (cmd.seed_init)
            seed_reg <= first ? rem[PW-1:0] : PW'(n_act - 9'd1);
        if (cmd.search && pass_v_reg && !found_reg)
        begin
            run_reg <= run_reg + {9'd0, nrd_reg};
            if ((run_reg + {9'd0, nrd_reg}) > {1'b0, rem})
                seed_reg <= idx_d_reg;
        end
        if ((pass_i || pass_r) && pass_v_reg)
        begin : upd
            logic [6:0] nd;
            logic [3:0] na;
            logic [15:0] st;
            logic [15:0] sc;
            nd = nrd_reg;
            na = ard_reg;
            if (pass_i)
            begin
                nd = drd_reg;
                na = 4'd0;
            end
            else if (drd_reg < nrd_reg)
            begin
                nd = drd_reg;
                na = 4'(chosen_reg);
            end
            near_mem[idx_d_reg] <= nd;
            asg_mem[idx_d_reg]  <= na;
            st = {1'b0, acc_total_reg} + {9'd0, nd};
            acc_total_reg <= st > 16'd32767 ? 15'd32767 : st[14:0];
            for (int c = 0; c < NC; c++)
                if (na == 4'(c))
                begin
                    sc = {1'b0, acc_c_reg[c]} + {9'd0, nd};
                    acc_c_reg[c] <= sc > 16'd32767 ? 15'd32767 : sc[14:0];
                end
        end
        if (cmd.commit_seed)
        begin
            seedp_reg[chosen_reg[KW-1:0] < KW'(NC) ? chosen_reg : '0] <= seed_reg;
            for (int c = 0; c < NC; c++)
                ccost_reg[c] <= acc_c_reg[c];
        end
    end

    // result fields
    always_comb
    begin
        st_next = dwsp_pkg::ST_OK;
        sp_next = '0;
        sn_next = '0;
        cc_next = '0;
        tc_next = '0;
        pd_next = '0;
        case (op_reg)
            dwsp_pkg::OP_LOAD:
            begin
                if ({1'b0, row_reg} >= n_act || {1'b0, col_reg} >= n_act)
                    st_next = dwsp_pkg::ST_BAD;
            end
            dwsp_pkg::OP_PICK:
            begin
                // flags taken when the item was accepted
                if (full_l_reg)
                    st_next = dwsp_pkg::ST_FULL;
                else if (zero_l_reg)
                    st_next = dwsp_pkg::ST_ZERO;
                else
                begin
                    sp_next = 8'(seedp_reg[chosen_reg - 1'b1]);
                    sn_next = 4'(chosen_reg - 1'b1);
                    cc_next = ccost_reg[chosen_reg - 1'b1];
                    tc_next = total_reg;
                end
            end
            dwsp_pkg::OP_RCLUS:
            begin
                if ({1'b0, csel_reg} >= 5'(chosen_reg))
                    st_next = dwsp_pkg::ST_BAD;
                else
                begin
                    sp_next = seedp_reg[csel_reg[KW-1:0]];
                    sn_next = csel_reg;
                    cc_next = ccost_reg[csel_reg[KW-1:0]];
                    tc_next = total_reg;
                end
            end
            default:
            begin
                if ({1'b0, row_reg} >= n_act)
                    st_next = dwsp_pkg::ST_BAD;
                else
                begin
                    if (ard_reg < 4'(NC))
                    begin
                        sp_next = seedp_reg[ard_reg[KW-1:0]];
                        cc_next = ccost_reg[ard_reg[KW-1:0]];
                    end
                    sn_next = ard_reg;
                    tc_next = total_reg;
                    pd_next = nrd_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            status         <= st_next;
            seed_point     <= sp_next;
            seed_number    <= sn_next;
            cluster_cost   <= cc_next;
            total_cost     <= tc_next;
            point_distance <= pd_next;
        end
    end

    always_comb
    begin
        sts.mod_done  = mod_done;
        sts.idx_last  = ({1'b0, idx_reg} == n_act - 9'd1);
        sts.found     = found_reg;
        sts.full      = (chosen_reg >= KW'(NC));
        sts.zero_cost = !first && (total_reg == '0);
        sts.first     = first;
    end

    `DWSP_ASSERT(a_chosen_range, chosen_reg <= KW'(NC), "seed count overflow")
    `DWSP_ASSERT_NEXT(a_commit_count, cmd.commit_seed, chosen_reg == $past(chosen_reg) + 1'b1,
        "commit did not advance seed count")
    `DWSP_ASSERT_IMP(a_pass_excl, pass_s, !pass_r && !pass_i, "overlapping passes")
endmodule

>>> hdl/dwsp_ctrl.sv
`include "distance_weighted_seed_picker_defines.svh"
module dwsp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_opcode,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  dwsp_pkg::sts_t sts,
    output dwsp_pkg::cmd_t cmd
);
    dwsp_pkg::state_t state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       tail_reg, tail_next;   // drain of the pass pipeline

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dwsp_pkg::S_IDLE;
            ov_reg    <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            tail_reg  <= tail_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        tail_next  = 1'b0;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            dwsp_pkg::S_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.load_inp = 1'b1;
                    case (in_opcode)
                        dwsp_pkg::OP_PICK:  state_next = dwsp_pkg::S_MOD;
                        dwsp_pkg::OP_RPNT:  state_next = dwsp_pkg::S_RDP;
                        default:            state_next = dwsp_pkg::S_OUT;
                    endcase
                end
            end
            dwsp_pkg::S_MOD:
            begin
                if (sts.full || sts.zero_cost)
                    state_next = dwsp_pkg::S_OUT;
                else
                begin
                    cmd.start_mod = 1'b1;
                    cmd.mod_total = !sts.first;
                    state_next = dwsp_pkg::S_RDC;
                end
            end
            dwsp_pkg::S_RDC:
            begin
                if (sts.mod_done)
                begin
                    cmd.clr_idx   = 1'b1;
                    cmd.seed_init = 1'b1;
                    // first seed initialises, later seeds search then scan
                    state_next = sts.first ? dwsp_pkg::S_INIT : dwsp_pkg::S_SEARCH;
                end
            end
            dwsp_pkg::S_INIT:
            begin
                cmd.init_pass = 1'b1;
                if (!tail_reg)
                begin
                    cmd.step_idx = 1'b1;
                    tail_next = sts.idx_last;
                end
                else
                    state_next = dwsp_pkg::S_DONE;
            end
            dwsp_pkg::S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (!tail_reg)
                begin
                    cmd.step_idx = 1'b1;
                    tail_next = sts.idx_last;
                end
                else
                    state_next = dwsp_pkg::S_TURN;
            end
            dwsp_pkg::S_TURN:
            begin
                cmd.clr_idx = 1'b1;
                state_next = dwsp_pkg::S_SCAN;
            end
            dwsp_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!tail_reg)
                begin
                    cmd.step_idx = 1'b1;
                    tail_next = sts.idx_last;
                end
                else
                    state_next = dwsp_pkg::S_DONE;
            end
            dwsp_pkg::S_DONE:
            begin
                cmd.commit_seed = 1'b1;
                state_next = dwsp_pkg::S_OUT;
            end
            dwsp_pkg::S_RDP:
            begin
                state_next = dwsp_pkg::S_OUT;
            end
            dwsp_pkg::S_OUT:
            begin
                cmd.capture = 1'b1;
                ov_next = 1'b1;
                state_next = dwsp_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dwsp_pkg::S_IDLE;
            end
        endcase
    end

    `DWSP_ASSERT_IMP(a_ready_idle, in_ready, state_reg == dwsp_pkg::S_IDLE,
        "ready outside idle")
    `DWSP_ASSERT_NEXT(a_capture_valid, cmd.capture, out_valid, "result not presented")
    `DWSP_ASSERT_IMP(a_one_pass, cmd.search, !cmd.scan, "search and scan together")
endmodule

>>> hdl/distance_weighted_seed_picker.sv
// Seed picker: load a distance matrix one entry per item, then pick up to
// five seeds k-means++ style. A pick runs a remainder unit, then one pass
// over the points for the prefix search and one for reassignment (only the
// latter for the first seed).
module distance_weighted_seed_picker
(
    input  logic        clk,
    input  logic        rst_n,
    dwsp_in_if.sink     in_ch,
    dwsp_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [8:0]     point_count_reg;
    dwsp_pkg::cmd_t cmd;
    dwsp_pkg::sts_t sts;
    logic           in_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {23'd0, point_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= 9'd256;
        else if (psel && penable && pwrite && paddr == 1'b0)
            point_count_reg <= pwdata[8:0];
    end

    assign in_ch.ready = in_ready;

    dwsp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dwsp_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (in_ch.opcode),
        .row_point      (in_ch.row_point),
        .col_point      (in_ch.col_point),
        .pair_distance  (in_ch.pair_distance),
        .random_word    (in_ch.random_word),
        .cluster_select (in_ch.cluster_select),
        .point_count    (point_count_reg),
        .do_load        (in_ch.valid && in_ready && in_ch.opcode == dwsp_pkg::OP_LOAD),
        .status         (out_ch.status),
        .seed_point     (out_ch.seed_point),
        .seed_number    (out_ch.seed_number),
        .cluster_cost   (out_ch.cluster_cost),
        .total_cost     (out_ch.total_cost),
        .point_distance (out_ch.point_distance)
    );
endmodule

>>> dv/dwsp_checker.sv
`timescale 1ns / 1ps

module dwsp_checker
    import dwsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dwsp_in_if          in_mon,
    dwsp_out_if         out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  seed_point;
        logic [3:0]  seed_number;
        logic [14:0] cluster_cost;
        logic [14:0] total_cost;
        logic [6:0]  point_distance;
    } seed_result_t;

    bit [6:0]    dist_mat [0:65535];
    bit [6:0]    near_dist [0:255];
    bit [3:0]    owner [0:255];
    int unsigned clus_cost [0:NUM_CLUSTERS-1];
    bit [7:0]    seed_at [0:NUM_CLUSTERS-1];
    int unsigned n_seeds;
    int unsigned all_cost;
    bit [8:0]    pt_count;

    seed_result_t result_q[$];

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        return (a + b > COST_CAP) ? COST_CAP : a + b;
    endfunction

    function automatic int unsigned live_points();
        if (pt_count < 2) return 2;
        if (pt_count > MAX_POINTS) return MAX_POINTS;
        return pt_count;
    endfunction

    task automatic predict_seed_result(output seed_result_t res);
        int unsigned n;
        int unsigned k;
        int unsigned seed;
        int unsigned r;
        int unsigned run;
        int unsigned c;
        int unsigned d;
        n = live_points();
        res = '0;
        case (in_mon.opcode)
            OP_LOAD:
            begin
                if (in_mon.row_point >= n || in_mon.col_point >= n)
                    res.status = ST_BAD;
                else
                begin
                    d = in_mon.pair_distance;
                    if (d > DIST_CAP) d = DIST_CAP;
                    dist_mat[{in_mon.row_point, in_mon.col_point}] = d[6:0];
                end
            end
            OP_PICK:
            begin
                k = n_seeds;
                if (k >= NUM_CLUSTERS)
                    res.status = ST_FULL;
                else if (k != 0 && all_cost == 0)
                    res.status = ST_ZERO;
                else
                begin
                    if (k == 0)
                    begin
                        seed = in_mon.random_word % n;
                        for (int i = 0; i < n; i++)
                        begin
                            owner[i] = 0;
                            near_dist[i] = dist_mat[i * MAX_POINTS + seed];
                        end
                    end
                    else
                    begin
                        r = in_mon.random_word % all_cost;
                        run = 0;
                        seed = n - 1;
                        for (int i = 0; i < n; i++)
                        begin
                            run += near_dist[i];
                            if (run > r)
                            begin
                                seed = i;
                                break;
                            end
                        end
                        for (int i = 0; i < n; i++)
                            if (dist_mat[i * MAX_POINTS + seed] < near_dist[i])
                            begin
                                near_dist[i] = dist_mat[i * MAX_POINTS + seed];
                                owner[i] = k[3:0];
                            end
                    end
                    seed_at[k] = seed[7:0];
                    n_seeds = k + 1;
                    for (int j = 0; j < NUM_CLUSTERS; j++) clus_cost[j] = 0;
                    all_cost = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        c = owner[i];
                        if (c < NUM_CLUSTERS) clus_cost[c] = sat_sum(clus_cost[c], near_dist[i]);
                        all_cost = sat_sum(all_cost, near_dist[i]);
                    end
                    res.seed_point   = seed[7:0];
                    res.seed_number  = k[3:0];
                    res.cluster_cost = clus_cost[k][14:0];
                    res.total_cost   = all_cost[14:0];
                end
            end
            OP_RCLUS:
            begin
                if (in_mon.cluster_select >= n_seeds)
                    res.status = ST_BAD;
                else
                begin
                    res.seed_point   = seed_at[in_mon.cluster_select];
                    res.seed_number  = in_mon.cluster_select;
                    res.cluster_cost = clus_cost[in_mon.cluster_select][14:0];
                    res.total_cost   = all_cost[14:0];
                end
            end
            default:
            begin
                if (in_mon.row_point >= n)
                    res.status = ST_BAD;
                else
                begin
                    c = owner[in_mon.row_point];
                    if (c < NUM_CLUSTERS)
                    begin
                        res.seed_point   = seed_at[c];
                        res.cluster_cost = clus_cost[c][14:0];
                    end
                    res.seed_number    = c[3:0];
                    res.total_cost     = all_cost[14:0];
                    res.point_distance = near_dist[in_mon.row_point];
                end
            end
        endcase
    endtask

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seed_result_t exp_res;
        seed_result_t got;
        if (!rst_n)
        begin
            n_seeds  = 0;
            all_cost = 0;
            pt_count = 9'd256;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                pt_count = pwdata[8:0];
            if (in_mon.valid && in_mon.ready)
            begin
                predict_seed_result(exp_res);
                result_q.push_back(exp_res);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.status, out_mon.seed_point, out_mon.seed_number,
                        out_mon.cluster_cost, out_mon.total_cost, out_mon.point_distance};
                if (result_q.size() == 0)
                    report("unexpected item", 1, 0);
                else
                begin
                    exp_res = result_q.pop_front();
                    if (got.status != exp_res.status)
                        report("status", got.status, exp_res.status);
                    if (got.seed_point != exp_res.seed_point)
                        report("seed_point", got.seed_point, exp_res.seed_point);
                    if (got.seed_number != exp_res.seed_number)
                        report("seed_number", got.seed_number, exp_res.seed_number);
                    if (got.cluster_cost != exp_res.cluster_cost)
                        report("cluster_cost", got.cluster_cost, exp_res.cluster_cost);
                    if (got.total_cost != exp_res.total_cost)
                        report("total_cost", got.total_cost, exp_res.total_cost);
                    if (got.point_distance != exp_res.point_distance)
                        report("point_distance", got.point_distance, exp_res.point_distance);
                end
            end
        end
        pending = result_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import dwsp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1070;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    bit          zero_mode;   // matrix built so the cost falls to zero after four seeds
    int          seed_n;      // point count used for seeding
    int          cur_n;
    int          items_sent;
    int          burst_left;
    bit          hold_req;
    int          cycles;

    dwsp_in_if  in_ch();
    dwsp_out_if out_ch();

    distance_weighted_seed_picker u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dwsp_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_item(logic [1:0] op, int row, int col, int pair_dist,
                             logic [31:0] rnd, int csel);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.row_point      <= row[7:0];
        in_ch.col_point      <= col[7:0];
        in_ch.pair_distance  <= pair_dist[6:0];
        in_ch.random_word    <= rnd;
        in_ch.cluster_select <= csel[3:0];
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_point_count(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 1'b0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int matrix_value(int r, int c);
        if (r == c) return 0;
        if (zero_mode)
            return (r % 4 == c % 4) ? 0 : $urandom_range(1, 127);
        return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 127);
    endfunction

    function automatic int pick_index();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, cur_n - 1) : $urandom_range(0, 255);
    endfunction

    task automatic random_item();
        int sel;
        int r;
        int c;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            r = pick_index();
            c = pick_index();
            if (r < cur_n && c < cur_n)
                send_item(OP_LOAD, r, c, matrix_value(r, c), $urandom, $urandom_range(0, 15));
            else
                send_item(OP_LOAD, r, c, $urandom_range(0, 127), $urandom, $urandom_range(0, 15));
        end
        else if (sel < 45)
            send_item(OP_PICK, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 127), $urandom, $urandom_range(0, 15));
        else if (sel < 70)
            send_item(OP_RCLUS, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 127), $urandom, $urandom_range(0, 15));
        else
            send_item(OP_RPNT, pick_index(), $urandom_range(0, 255),
                      $urandom_range(0, 127), $urandom, $urandom_range(0, 15));
    endtask

    // receiver: runs of steady acceptance alternate with choppy stretches, plus one long hold on request
    initial
    begin
        int run_len;
        bit choppy;
        run_len = 0;
        choppy  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                if (run_len == 0)
                begin
                    choppy  = $urandom_range(0, 1);
                    run_len = $urandom_range(5, 60);
                end
                run_len--;
                out_ch.ready <= choppy ? 1'($urandom_range(0, 1)) : 1'b1;
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = 1'b0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.opcode         = OP_LOAD;
        in_ch.row_point      = '0;
        in_ch.col_point      = '0;
        in_ch.pair_distance  = '0;
        in_ch.random_word    = '0;
        in_ch.cluster_select = '0;
        out_ch.ready         = 1'b0;
        hold_req             = 1'b0;
        items_sent           = 0;
        burst_left           = 0;
        zero_mode            = $urandom_range(0, 1);
        seed_n               = $urandom_range(8, 20);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-size matrix: edge entries, distance clamp, unchosen cluster reads
        cur_n = 256;
        send_item(OP_LOAD, 0, 0, 0, 32'h0, 0);
        send_item(OP_LOAD, 255, 255, 127, 32'hFFFF_FFFF, 15);
        send_item(OP_LOAD, 255, 0, 64, 32'h0, 0);
        send_item(OP_LOAD, 0, 255, 65, 32'h0, 0);
        send_item(OP_RCLUS, 0, 0, 0, 32'h0, 0);
        send_item(OP_RCLUS, 0, 0, 0, 32'h0, 15);
        drain();
        write_point_count(511);
        send_item(OP_LOAD, 200, 17, 1, 32'h0, 0);
        drain();
        write_point_count(0);
        send_item(OP_LOAD, 2, 0, 5, 32'h0, 0);
        send_item(OP_LOAD, 0, 5, 5, 32'h0, 0);
        send_item(OP_LOAD, 1, 1, 3, 32'h0, 0);
        send_item(OP_RCLUS, 0, 0, 0, 32'h0, 3);
        drain();
        write_point_count(1);
        send_item(OP_LOAD, 1, 0, 9, 32'h0, 0);
        drain();

        // seeding set: whole matrix first, so every pick reads written entries
        write_point_count(seed_n);
        cur_n = seed_n;
        for (int r = 0; r < seed_n; r++)
            for (int c = 0; c < seed_n; c++)
                send_item(OP_LOAD, r, c, matrix_value(r, c), $urandom, 0);
        send_item(OP_PICK, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(OP_RPNT, 0, 0, 0, 32'h0, 0);
        send_item(OP_RPNT, seed_n - 1, 0, 0, 32'h0, 0);
        send_item(OP_RPNT, 255, 0, 0, 32'h0, 0);
        send_item(OP_PICK, 0, 0, 0, 32'h0, 0);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent == 500)
                hold_req = 1'b1;
            if (items_sent == 700)
            begin
                drain();
                write_point_count(2);
                cur_n = 2;
                repeat (60) random_item();
                drain();
                write_point_count(seed_n);
                cur_n = seed_n;
            end
            random_item();
        end
        // picks until the seeding ends, whichever way it ends
        repeat (8) send_item(OP_PICK, 0, 0, 0, $urandom, 0);
        drain();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dwsp_pkg.sv
hdl/dwsp_if.sv
hdl/dwsp_moddiv.sv
hdl/dwsp_datapath.sv
hdl/dwsp_ctrl.sv
hdl/distance_weighted_seed_picker.sv
dv/dwsp_checker.sv
dv/tb.sv
